[hdl/tdpt_pkg.sv]
// Package for the trial-division prime test: control word type, step,
// condition and operation codes, and the microcode table.
// No dependencies.
package tdpt_pkg;

	// Sequencer step codes
	localparam logic [3:0] STEP_IDLE  = 4'd0;
	localparam logic [3:0] STEP_LT2   = 4'd1;
	localparam logic [3:0] STEP_LT4   = 4'd2;
	localparam logic [3:0] STEP_EVEN  = 4'd3;
	localparam logic [3:0] STEP_BOUND = 4'd4;
	localparam logic [3:0] STEP_DIV   = 4'd5;
	localparam logic [3:0] STEP_REM   = 4'd6;
	localparam logic [3:0] STEP_EMITN = 4'd7;
	localparam logic [3:0] STEP_EMITP = 4'd8;

	// Jump conditions
	localparam logic [2:0] C_REQ   = 3'd0; // request accepted
	localparam logic [2:0] C_LT2   = 3'd1; // value below two
	localparam logic [2:0] C_LT4   = 3'd2; // value below four
	localparam logic [2:0] C_EVEN  = 3'd3; // value even
	localparam logic [2:0] C_SQGT  = 3'd4; // divisor squared above value
	localparam logic [2:0] C_CNTZ  = 3'd5; // last divide bit
	localparam logic [2:0] C_REMZ  = 3'd6; // remainder zero
	localparam logic [2:0] C_OFREE = 3'd7; // result register can take a word

	// Datapath operations
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_INIT   = 3'd2;
	localparam logic [2:0] OP_DSTART = 3'd3;
	localparam logic [2:0] OP_DSTEP  = 3'd4;
	localparam logic [2:0] OP_DNEXT  = 3'd5;
	localparam logic [2:0] OP_EMIT0  = 3'd6;
	localparam logic [2:0] OP_EMIT1  = 3'd7;

	typedef struct packed {
		logic [2:0] cond;
		logic [2:0] op;
		logic [3:0] jump_t; // next step when the condition holds
		logic [3:0] jump_f; // next step otherwise
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [3:0] step);
		ctrl_t w;
		unique case (step)
			STEP_IDLE:  w = '{C_REQ,   OP_LOAD,   STEP_LT2,   STEP_IDLE};
			STEP_LT2:   w = '{C_LT2,   OP_NONE,   STEP_EMITN, STEP_LT4};
			STEP_LT4:   w = '{C_LT4,   OP_NONE,   STEP_EMITP, STEP_EVEN};
			STEP_EVEN:  w = '{C_EVEN,  OP_INIT,   STEP_EMITN, STEP_BOUND};
			STEP_BOUND: w = '{C_SQGT,  OP_DSTART, STEP_EMITP, STEP_DIV};
			STEP_DIV:   w = '{C_CNTZ,  OP_DSTEP,  STEP_REM,   STEP_DIV};
			STEP_REM:   w = '{C_REMZ,  OP_DNEXT,  STEP_EMITN, STEP_BOUND};
			STEP_EMITN: w = '{C_OFREE, OP_EMIT0,  STEP_IDLE,  STEP_EMITN};
			STEP_EMITP: w = '{C_OFREE, OP_EMIT1,  STEP_IDLE,  STEP_EMITP};
			default:    w = '{C_REQ,   OP_NONE,   STEP_IDLE,  STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

[hdl/trial_division_prime_test.sv]
// Trial-division primality test, top level: microcode sequencer, restoring
// divider datapath and result register.
// Depends on tdpt_pkg (control word type, codes, microcode table).

// Each accepted request carries one non-negative value and a last-item mark;
// exactly one result comes back per request, in order, with the value, the
// mark and is_prime. Zero and one are not prime, two and three are prime,
// other even values are not; an odd value is tried against 3, 5, 7, ...
// while the divisor squared does not exceed it. One request is worked on at
// a time: req_stall is high from acceptance until the result is written to
// the output register, which then holds it for the consumer while the next
// request is taken. Zero and one are settled by the first check, two and
// three by the second, other even values by the third; each odd divisor
// tried on an odd value above three costs a bound check, a full divide and
// a remainder check. A stalled output register delays the write, and the
// next request can be taken in the cycle after the write. The run time for
// odd values is set by the single shared restoring divider, which takes
// one value bit per cycle for each divisor.
// The divisor bound is kept as a running square (d*d grows by 4d + 4 per
// step of two), so no multiplier is needed.
module trial_division_prime_test #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  last_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [VALUE_BITS-1:0] value_out,
	output logic                  is_prime,
	output logic                  last_out
);

	// Divisor never exceeds sqrt(value) + 2
	localparam int DW = VALUE_BITS / 2 + 2;
	// Running square overshoots the value by at most 4*sqrt(value) + 4
	localparam int SW = VALUE_BITS + 1;
	localparam int CW = $clog2(VALUE_BITS);

	logic [3:0]            step_q;
	tdpt_pkg::ctrl_t       ctrl;
	logic                  cond;

	logic [VALUE_BITS-1:0] v_q;
	logic                  last_q;
	logic [DW-1:0]         d_q;
	logic [SW-1:0]         sq_q;
	logic [DW-1:0]         r_q;
	logic [CW-1:0]         cnt_q;

	logic                  res_valid_q;
	logic                  out_free;
	logic                  req_acc;

	logic [DW:0]           r_sh;
	logic [DW:0]           r_sub;
	logic                  r_ge;
	logic [SW-1:0]         sq_inc;

	assign req_stall = (step_q != tdpt_pkg::STEP_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign out_free  = !res_valid_q || !res_stall;

	assign ctrl = tdpt_pkg::ucode(step_q);

	// Restoring divide step: bring in the next value bit, subtract if it fits
	assign r_sh  = {r_q, v_q[cnt_q]};
	assign r_sub = r_sh - {1'b0, d_q};
	assign r_ge  = (r_sh >= {1'b0, d_q});

	// (d + 2)^2 = d^2 + 4d + 4
	assign sq_inc = (SW'(d_q) << 2) + SW'(4);

	always_comb begin
		unique case (ctrl.cond)
			tdpt_pkg::C_REQ:   cond = req_acc;
			tdpt_pkg::C_LT2:   cond = (v_q[VALUE_BITS-1:1] == '0);
			tdpt_pkg::C_LT4:   cond = (v_q[VALUE_BITS-1:2] == '0);
			tdpt_pkg::C_EVEN:  cond = !v_q[0];
			tdpt_pkg::C_SQGT:  cond = (sq_q > SW'(v_q));
			tdpt_pkg::C_CNTZ:  cond = (cnt_q == '0);
			tdpt_pkg::C_REMZ:  cond = (r_q == '0);
			tdpt_pkg::C_OFREE: cond = out_free;
			default:           cond = 1'b0;
		endcase
	end

	// Step counter: take the jump named by the current control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tdpt_pkg::STEP_IDLE;
		end else begin
			step_q <= cond ? ctrl.jump_t : ctrl.jump_f;
		end
	end

	// Datapath: no reset, every register is loaded before it is read
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			tdpt_pkg::OP_LOAD: begin
				// Sample every idle cycle; the accepted request is the last one sampled
				v_q    <= value;
				last_q <= last_item;
			end
			tdpt_pkg::OP_INIT: begin
				d_q  <= DW'(3);
				sq_q <= SW'(9);
			end
			tdpt_pkg::OP_DSTART: begin
				r_q   <= '0;
				cnt_q <= CW'(VALUE_BITS - 1);
			end
			tdpt_pkg::OP_DSTEP: begin
				r_q   <= r_ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
				cnt_q <= cnt_q - CW'(1);
			end
			tdpt_pkg::OP_DNEXT: begin
				d_q  <= d_q + DW'(2);
				sq_q <= sq_q + sq_inc;
			end
			default: begin
			end
		endcase
	end

	// Result register: hold the word until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((ctrl.op == tdpt_pkg::OP_EMIT0 || ctrl.op == tdpt_pkg::OP_EMIT1)
				&& out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == tdpt_pkg::OP_EMIT0 || ctrl.op == tdpt_pkg::OP_EMIT1) && out_free) begin
			value_out <= v_q;
			is_prime  <= (ctrl.op == tdpt_pkg::OP_EMIT1);
			last_out  <= last_q;
		end
	end

	// An accepted request always starts the small-value checks
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (step_q == tdpt_pkg::STEP_LT2))
		else $error("request accepted but sequencer did not start");

	// Partial remainder stays below the divisor while dividing
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tdpt_pkg::STEP_DIV) |-> (r_q < d_q))
		else $error("partial remainder not below divisor");

	// Only odd divisors are tried
	a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tdpt_pkg::STEP_BOUND || step_q == tdpt_pkg::STEP_DIV
		 || step_q == tdpt_pkg::STEP_REM) |-> d_q[0])
		else $error("even divisor in trial loop");

	// No even value other than two is reported prime
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && is_prime) |-> (value_out[0] || value_out == VALUE_BITS'(2)))
		else $error("even value flagged prime");

endmodule

[dv/tb_trial_division_prime_test.sv]
// Testbench for trial_division_prime_test: directed table, then random requests,
// with every result checked in order against a trial-division predictor or a typed flag.
// Depends only on the trial_division_prime_test module.
module tb_trial_division_prime_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_W = 31;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_REQUESTS = 80;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	// Slowest run is one 31-bit prime plus the rest; allow several times that.
	localparam longint TIMEOUT_CYCLES = 6_000_000;
	localparam int N_DIR = 20;

	// One verdict per request: the value, its flag and the last-item mark.
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               prime;
		logic               last;
	} verdict_t;

	// Directed row; typed means the flag is written here rather than predicted.
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
		bit                 typed;
		logic               prime;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [VALUE_W-1:0] value;
	logic               last_item;
	logic               res_valid;
	logic               res_stall;
	logic [VALUE_W-1:0] value_out;
	logic               is_prime;
	logic               last_out;

	verdict_t    verdict_q[$];
	int unsigned error_count = 0;
	int unsigned results_checked = 0;
	int unsigned requests_sent = 0;
	int          tx_idle_pct = 6;
	int          rx_idle_pct = 57;
	bit          hold_request = 1'b0;

	// Small values, squares of primes on the divisor bound, extremes of the field.
	stim_row_t dir_rows [0:N_DIR-1] = '{
		'{31'd0,          1'b0, 1'b1, 1'b0},  // zero is not prime
		'{31'd1,          1'b1, 1'b1, 1'b0},  // one is not prime
		'{31'd2,          1'b0, 1'b1, 1'b1},
		'{31'd3,          1'b0, 1'b1, 1'b1},
		'{31'd4,          1'b0, 1'b1, 1'b0},
		'{31'd5,          1'b0, 1'b0, 1'b0},
		'{31'd6,          1'b1, 1'b0, 1'b0},
		'{31'd7,          1'b0, 1'b0, 1'b0},
		'{31'd9,          1'b0, 1'b0, 1'b0},  // divisor squared equals value
		'{31'd15,         1'b0, 1'b0, 1'b0},
		'{31'd25,         1'b0, 1'b0, 1'b0},
		'{31'd49,         1'b0, 1'b0, 1'b0},
		'{31'd63001,      1'b0, 1'b0, 1'b0},  // 251 squared
		'{31'd4093,       1'b0, 1'b0, 1'b0},
		'{31'd4095,       1'b1, 1'b0, 1'b0},
		'{31'h2AAAAAAA,   1'b0, 1'b1, 1'b0},  // even
		'{31'h55555555,   1'b0, 1'b0, 1'b0},
		'{31'h7FFFFFFE,   1'b1, 1'b1, 1'b0},  // largest even
		'{31'h7FFFFFFD,   1'b0, 1'b0, 1'b0},
		'{31'h7FFFFFFF,   1'b1, 1'b0, 1'b0}   // largest value, slowest request
	};

	trial_division_prime_test #(
		.VALUE_BITS(VALUE_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.value     (value),
		.last_item (last_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value_out (value_out),
		.is_prime  (is_prime),
		.last_out  (last_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Trial division: 2, then odd divisors while d*d <= n (tested as d <= n/d).
	function automatic logic prime_by_division(input logic [VALUE_W-1:0] v);
		longint unsigned n;
		longint unsigned d;
		n = 64'(v);
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if ((n & 1) == 0)
			return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Mostly cheap values; large ones are forced onto a small factor to keep the run short.
	function automatic logic [VALUE_W-1:0] draw_value();
		int unsigned        pick;
		int unsigned        factor;
		logic [VALUE_W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 55) begin
			v = VALUE_W'($urandom_range(4095));
		end else if (pick < 70) begin
			v = VALUE_W'($urandom_range(65535));
		end else if (pick < 73) begin
			v = VALUE_W'($urandom_range(1 << 20));
		end else if (pick < 95) begin
			v = VALUE_W'($urandom);
			factor = 3 + 2 * $urandom_range(2);
			v = VALUE_W'(v - (v % factor));
		end else begin
			v = VALUE_W'($urandom_range(3));
		end
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $time, what);
		error_count++;
	endtask

	// Offer one request; hold the payload until the block takes it, then record the verdict.
	task automatic send_request(input logic [VALUE_W-1:0] v, input logic l,
			input bit typed, input logic typed_prime);
		verdict_t want;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			value     <= VALUE_W'($urandom);
			last_item <= 1'($urandom_range(1));
			@(posedge clk);
		end
		req_valid <= 1'b1;
		value     <= v;
		last_item <= l;
		do
			@(posedge clk);
		while (req_stall);
		want.value = v;
		want.last  = l;
		want.prime = typed ? typed_prime : prime_by_division(v);
		verdict_q = {verdict_q, want};
		requests_sent++;
	endtask

	// Reset once, then walk the directed table and the random requests through three idle phases.
	initial begin : request_side
		int k;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		value     <= '0;
		last_item <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Phase one: sender rarely idles, receiver often stalls.
		tx_idle_pct = 6;
		rx_idle_pct = 57;
		for (k = 0; k < N_DIR; k++)
			send_request(dir_rows[k].value, dir_rows[k].last, dir_rows[k].typed,
				dir_rows[k].prime);
		for (k = 0; k < RANDOM_REQUESTS; k++) begin
			if (k == RANDOM_REQUESTS / 3) begin
				// Phase two: swap the idle rates.
				tx_idle_pct = 57;
				rx_idle_pct = 6;
			end else if (k == 2 * RANDOM_REQUESTS / 3) begin
				// Phase three: no idling, and one long output hold to back the block up.
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_request = 1'b1;
			end
			send_request(draw_value(), ($urandom_range(7) == 0), 1'b0, 1'b0);
		end
		req_valid <= 1'b0;

		// Drain: wait for every verdict, then a few more cycles for stray results.
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d from the directed table), checked %0d results.",
			requests_sent, N_DIR, results_checked);
		$display("Idle phases on both sides were covered, plus one %0d-cycle output hold.",
			LONG_HOLD_CYCLES);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Drive res_stall: random stalls at the phase rate, or a long hold when asked.
	initial begin : result_side
		int unsigned hold_left;
		hold_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && hold_left == 0) begin
				hold_left    = LONG_HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Compare every accepted result with the oldest pending verdict.
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result, value_out %0d", value_out));
			end else begin
				want = verdict_q.pop_front();
				results_checked++;
				if (value_out !== want.value)
					report_mismatch($sformatf("value_out: got %0d, expected %0d",
						value_out, want.value));
				if (is_prime !== want.prime)
					report_mismatch($sformatf("is_prime for %0d: got %0d, expected %0d",
						want.value, is_prime, want.prime));
				if (last_out !== want.last)
					report_mismatch($sformatf("last_out for %0d: got %0d, expected %0d",
						want.value, last_out, want.last));
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timeout with %0d results still pending", verdict_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[trial_division_prime_test.f]
hdl/tdpt_pkg.sv
hdl/trial_division_prime_test.sv
dv/tb_trial_division_prime_test.sv
